// ----- hdl/i2cw_pkg.sv -----
// ============================================================================
// I2C byte writer package
// Word types and sequencer phase codes shared by the I2C byte writer modules.
// ============================================================================
package i2cw_pkg;

    // Request word: one delay tick or one submitted byte.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       sda_level;
    } req_t;

    // Response word: line levels and status for one request.
    typedef struct packed {
        logic scl_release;
        logic sda_release;
        logic ready_res;
        logic ack_valid;
        logic nack;
        logic rejected;
    } rsp_t;

    // Request kinds.
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SUBMIT = 1'b1;

    // Sequencer phases.
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_A  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_B  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_LOW  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_HIGH = 4'd4;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ACK_SMP  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ACK_HOLD = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STOP_A   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_STOP_B   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_STOP_C   = 4'd10;

    // Index of the last data bit of a byte.
    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

// ----- hdl/i2cw_seq.sv -----
// ============================================================================
// I2C byte writer sequencer
// Bus phase state and the step taken for each accepted word.
// ============================================================================
module i2cw_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  i2cw_pkg::req_t item,
    output i2cw_pkg::rsp_t result
);

    logic [i2cw_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [2:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic       stop_pending_reg, stop_pending_next;
    logic       scl_line_reg, scl_line_next;
    logic       sda_line_reg, sda_line_next;
    logic       in_trans_reg, in_trans_next;

    always_comb
    begin
        logic [i2cw_pkg::PHASE_W-1:0] cur;
        logic scl_o;
        logic sda_o;
        logic ackv;
        logic nk;
        logic rej;

        cur = (phase_reg > i2cw_pkg::PH_STOP_C) ? i2cw_pkg::PH_IDLE : phase_reg;
        phase_next        = cur;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        stop_pending_next = stop_pending_reg;
        scl_line_next     = scl_line_reg;
        sda_line_next     = sda_line_reg;
        in_trans_next     = in_trans_reg;
        ackv = 1'b0;
        nk   = 1'b0;
        rej  = 1'b0;

        if (item.kind == i2cw_pkg::KIND_SUBMIT)
        begin
            if (cur != i2cw_pkg::PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                shift_next        = item.data_byte;
                bit_count_next    = 3'd0;
                stop_pending_next = item.last_byte;
                if (item.first_byte || !in_trans_reg)
                begin
                    phase_next = i2cw_pkg::PH_START_A;
                end
                else
                begin
                    phase_next = i2cw_pkg::PH_BIT_LOW;
                end
            end
            scl_o = scl_line_reg;
            sda_o = sda_line_reg;
        end
        else
        begin
            case (cur)
                i2cw_pkg::PH_START_A:
                begin
                    scl_line_next = 1'b1;
                    sda_line_next = 1'b1;
                    phase_next    = i2cw_pkg::PH_START_B;
                end
                i2cw_pkg::PH_START_B:
                begin
                    scl_line_next = 1'b1;
                    sda_line_next = 1'b0;
                    in_trans_next = 1'b1;
                    phase_next    = i2cw_pkg::PH_BIT_LOW;
                end
                i2cw_pkg::PH_BIT_LOW:
                begin
                    scl_line_next = 1'b0;
                    sda_line_next = shift_reg[7];
                    phase_next    = i2cw_pkg::PH_BIT_HIGH;
                end
                i2cw_pkg::PH_BIT_HIGH:
                begin
                    scl_line_next = 1'b1;
                    if (bit_count_reg == i2cw_pkg::LAST_BIT)
                    begin
                        phase_next = i2cw_pkg::PH_ACK_LOW;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + 3'd1;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        phase_next     = i2cw_pkg::PH_BIT_LOW;
                    end
                end
                i2cw_pkg::PH_ACK_LOW:
                begin
                    scl_line_next = 1'b0;
                    sda_line_next = 1'b1;
                    phase_next    = i2cw_pkg::PH_ACK_SMP;
                end
                i2cw_pkg::PH_ACK_SMP:
                begin
                    scl_line_next = 1'b1;
                    sda_line_next = 1'b1;
                    ackv          = 1'b1;
                    nk            = item.sda_level;
                    phase_next    = i2cw_pkg::PH_ACK_HOLD;
                end
                i2cw_pkg::PH_ACK_HOLD:
                begin
                    scl_line_next = 1'b1;
                    sda_line_next = 1'b1;
                    phase_next    = stop_pending_reg ? i2cw_pkg::PH_STOP_A
                                                     : i2cw_pkg::PH_IDLE;
                end
                i2cw_pkg::PH_STOP_A:
                begin
                    scl_line_next = 1'b0;
                    sda_line_next = 1'b0;
                    phase_next    = i2cw_pkg::PH_STOP_B;
                end
                i2cw_pkg::PH_STOP_B:
                begin
                    scl_line_next = 1'b1;
                    sda_line_next = 1'b0;
                    phase_next    = i2cw_pkg::PH_STOP_C;
                end
                i2cw_pkg::PH_STOP_C:
                begin
                    scl_line_next     = 1'b1;
                    sda_line_next     = 1'b1;
                    stop_pending_next = 1'b0;
                    in_trans_next     = 1'b0;
                    phase_next        = i2cw_pkg::PH_IDLE;
                end
                default:
                begin
                end
            endcase
            scl_o = scl_line_next;
            sda_o = sda_line_next;
            // The reported levels are the ones above; the held SCL is then
            // pulled low when idling inside an open transaction, or ahead of
            // the stop so that SDA can fall while SCL is low.
            if (phase_next == i2cw_pkg::PH_IDLE && scl_o && sda_o && in_trans_next)
            begin
                scl_line_next = 1'b0;
            end
            else if (phase_next == i2cw_pkg::PH_STOP_A)
            begin
                scl_line_next = 1'b0;
            end
        end

        result.scl_release = scl_o;
        result.sda_release = sda_o;
        result.ready_res   = (phase_next == i2cw_pkg::PH_IDLE);
        result.ack_valid   = ackv;
        result.nack        = nk;
        result.rejected    = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= i2cw_pkg::PH_IDLE;
            bit_count_reg    <= 3'd0;
            shift_reg        <= 8'd0;
            stop_pending_reg <= 1'b0;
            scl_line_reg     <= 1'b1;
            sda_line_reg     <= 1'b1;
            in_trans_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            stop_pending_reg <= stop_pending_next;
            scl_line_reg     <= scl_line_next;
            sda_line_reg     <= sda_line_next;
            in_trans_reg     <= in_trans_next;
        end
    end

endmodule

// ----- hdl/i2c_master_byte_writer_top.sv -----
// ============================================================================
// I2C master byte writer
// Open-drain I2C write sequencer driven by delay ticks and byte submissions.
// ============================================================================
// Throughput: one request word per cycle while req_stall is low; the sequencer
// steps once per word, and each response is registered in the output buffer.
// This two-entry output buffer keeps requests flowing while a response waits.
// Reset: asynchronous, active low; the sequencer returns to idle with both bus
// lines released and no transaction open, and the output buffer empties.
module i2c_master_byte_writer_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  i2cw_pkg::req_t req_word,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output i2cw_pkg::rsp_t rsp_word
);

    // Each request word advances the sequencer by exactly one step, so the
    // step is taken in the same cycle the word is accepted.  Its response is
    // registered in the main output register, or in the skid register when
    // the main one is still held by a stalled consumer.
    logic           req_fire;
    logic           rsp_fire;
    i2cw_pkg::rsp_t step_rsp;

    logic           out_valid_reg;
    i2cw_pkg::rsp_t out_word_reg;
    logic           skid_valid_reg;
    i2cw_pkg::rsp_t skid_word_reg;

    // Stall only when the skid register is occupied; this depends on
    // registered state alone, so there is no combinational stall path.
    assign req_stall = skid_valid_reg;
    assign req_fire  = req_valid && !skid_valid_reg;
    assign rsp_fire  = out_valid_reg && !rsp_stall;

    i2cw_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (req_fire),
        .item   (req_word),
        .result (step_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // No request is taken while the skid register is full.
            if (rsp_fire)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (req_fire)
        begin
            if (!out_valid_reg || rsp_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (rsp_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (rsp_fire)
            begin
                out_word_reg <= skid_word_reg;
            end
        end
        else if (req_fire)
        begin
            if (!out_valid_reg || rsp_fire)
            begin
                out_word_reg <= step_rsp;
            end
            else
            begin
                skid_word_reg <= step_rsp;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

// ----- bench/tb_i2c_master_byte_writer_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// I2C master byte writer testbench
// Drives tick and byte-submit words into the I2C byte writer and checks every
// response word against a cycle-free model of the bus sequencer. A short table
// of directed words comes first, then randomized write transactions with
// random gaps on the request side and random stalls on the response side.
// ============================================================================
module tb_i2c_master_byte_writer_top;

    // Run length and safety limit. The slowest legal run is roughly every
    // word waiting out a long sender gap and a long response stall, plus the
    // one long back-pressure window, so the limit sits far above that.
    localparam int WORK_WORDS   = 900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRESSURE_AT  = 250;
    localparam int PRESSURE_LEN = 200;
    localparam int ERR_PRINT    = 40;
    localparam int REQ_W        = $bits(i2cw_pkg::req_t);

    // Response words that can be read straight off the sequencer description.
    // Field order: scl_release, sda_release, ready_res, ack_valid, nack, rejected.
    localparam i2cw_pkg::rsp_t RSP_IDLE_RELEASED = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam i2cw_pkg::rsp_t RSP_BUSY_RELEASED = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam i2cw_pkg::rsp_t RSP_BUSY_REJECTED = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam i2cw_pkg::rsp_t RSP_NACK_SAMPLED  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    typedef struct {
        i2cw_pkg::req_t word;
        bit             has_fixed;
        i2cw_pkg::rsp_t fixed_rsp;
    } stim_row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    i2cw_pkg::req_t req_word  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    i2cw_pkg::rsp_t rsp_word;

    // Expected response words, oldest first.
    i2cw_pkg::rsp_t line_levels_due[$];

    i2c_master_byte_writer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d responses outstanding",
                     $realtime, line_levels_due.size());
            $display("i2c_master_byte_writer_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Bus sequencer model. It keeps its own copy of the phase, the byte being
    // shifted, the held line levels and whether a transaction is open, and
    // steps once per accepted request word, exactly as the block does.
    // ------------------------------------------------------------------------
    logic [i2cw_pkg::PHASE_W-1:0] seq_phase = i2cw_pkg::PH_IDLE;
    logic [2:0]         bits_sent    = '0;
    logic [7:0]         tx_shift     = '0;
    logic               stop_wanted  = 1'b0;
    logic               scl_held     = 1'b1;
    logic               sda_held     = 1'b1;
    logic               txn_open     = 1'b0;

    int unsigned n_bytes_taken  = 0;
    int unsigned n_rejected     = 0;
    int unsigned n_nack         = 0;
    int unsigned n_ack          = 0;
    int unsigned n_stops        = 0;
    int unsigned n_restarts     = 0;
    int unsigned n_idle_ticks   = 0;

    task automatic i2c_bus_step(input i2cw_pkg::req_t w, output i2cw_pkg::rsp_t r);
        logic ack_seen;
        logic ack_level;
        logic refused;
        ack_seen  = 1'b0;
        ack_level = 1'b0;
        refused   = 1'b0;
        if (w.kind == i2cw_pkg::KIND_SUBMIT)
        begin
            // A submit takes no bus time; it only loads the byte.
            if (seq_phase != i2cw_pkg::PH_IDLE)
            begin
                refused = 1'b1;
            end
            else
            begin
                tx_shift    = w.data_byte;
                bits_sent   = '0;
                stop_wanted = w.last_byte;
                if (w.first_byte || !txn_open)
                begin
                    if (txn_open)
                    begin
                        n_restarts++;
                    end
                    seq_phase = i2cw_pkg::PH_START_A;
                end
                else
                begin
                    seq_phase = i2cw_pkg::PH_BIT_LOW;
                end
                n_bytes_taken++;
            end
            r.scl_release = scl_held;
            r.sda_release = sda_held;
        end
        else
        begin
            case (seq_phase)
                i2cw_pkg::PH_START_A:
                begin
                    scl_held  = 1'b1;
                    sda_held  = 1'b1;
                    seq_phase = i2cw_pkg::PH_START_B;
                end
                i2cw_pkg::PH_START_B:
                begin
                    // SDA falls while SCL is high: the start condition.
                    scl_held  = 1'b1;
                    sda_held  = 1'b0;
                    txn_open  = 1'b1;
                    seq_phase = i2cw_pkg::PH_BIT_LOW;
                end
                i2cw_pkg::PH_BIT_LOW:
                begin
                    scl_held  = 1'b0;
                    sda_held  = tx_shift[7];
                    seq_phase = i2cw_pkg::PH_BIT_HIGH;
                end
                i2cw_pkg::PH_BIT_HIGH:
                begin
                    scl_held = 1'b1;
                    if (bits_sent == i2cw_pkg::LAST_BIT)
                    begin
                        seq_phase = i2cw_pkg::PH_ACK_LOW;
                    end
                    else
                    begin
                        bits_sent = bits_sent + 3'd1;
                        tx_shift  = {tx_shift[6:0], 1'b0};
                        seq_phase = i2cw_pkg::PH_BIT_LOW;
                    end
                end
                i2cw_pkg::PH_ACK_LOW:
                begin
                    scl_held  = 1'b0;
                    sda_held  = 1'b1;
                    seq_phase = i2cw_pkg::PH_ACK_SMP;
                end
                i2cw_pkg::PH_ACK_SMP:
                begin
                    scl_held  = 1'b1;
                    sda_held  = 1'b1;
                    ack_seen  = 1'b1;
                    ack_level = w.sda_level;
                    seq_phase = i2cw_pkg::PH_ACK_HOLD;
                end
                i2cw_pkg::PH_ACK_HOLD:
                begin
                    scl_held  = 1'b1;
                    sda_held  = 1'b1;
                    seq_phase = stop_wanted ? i2cw_pkg::PH_STOP_A : i2cw_pkg::PH_IDLE;
                end
                i2cw_pkg::PH_STOP_A:
                begin
                    // SDA goes low before SCL is released, so no false start.
                    scl_held  = 1'b0;
                    sda_held  = 1'b0;
                    seq_phase = i2cw_pkg::PH_STOP_B;
                end
                i2cw_pkg::PH_STOP_B:
                begin
                    scl_held  = 1'b1;
                    sda_held  = 1'b0;
                    seq_phase = i2cw_pkg::PH_STOP_C;
                end
                i2cw_pkg::PH_STOP_C:
                begin
                    scl_held    = 1'b1;
                    sda_held    = 1'b1;
                    stop_wanted = 1'b0;
                    txn_open    = 1'b0;
                    seq_phase   = i2cw_pkg::PH_IDLE;
                    n_stops++;
                end
                default:
                begin
                    n_idle_ticks++;
                end
            endcase
            r.scl_release = scl_held;
            r.sda_release = sda_held;
            // The reported levels are those of this interval; the held SCL
            // then drops for the next one when a byte ends inside an open
            // transaction, or when the stop sequence is about to begin.
            if (!ack_seen && scl_held && sda_held && txn_open
                && seq_phase == i2cw_pkg::PH_IDLE)
            begin
                scl_held = 1'b0;
            end
            else if (seq_phase == i2cw_pkg::PH_STOP_A)
            begin
                scl_held = 1'b0;
            end
        end
        r.ready_res = (seq_phase == i2cw_pkg::PH_IDLE);
        r.ack_valid = ack_seen;
        r.nack      = ack_level;
        r.rejected  = refused;
        if (refused)
        begin
            n_rejected++;
        end
        if (ack_seen)
        begin
            if (ack_level)
            begin
                n_nack++;
            end
            else
            begin
                n_ack++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side. Words change at the falling edge; acceptance is seen at
    // the rising edge. The gap before a word is usually zero or short and now
    // and then long; during calm stretches there is no gap at all.
    // ------------------------------------------------------------------------
    bit   sender_calm = 1'b0;

    task automatic send_word(input i2cw_pkg::req_t w, input bit has_fixed,
                             input i2cw_pkg::rsp_t fixed_rsp);
        i2cw_pkg::rsp_t predicted;
        int   gap;
        int   pick;
        pick = $urandom_range(0, 99);
        if (sender_calm || pick < 55)
        begin
            gap = 0;
        end
        else if (pick < 92)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_word  <= w;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        i2c_bus_step(w, predicted);
        line_levels_due.push_back(has_fixed ? fixed_rsp : predicted);
    endtask

    function automatic i2cw_pkg::req_t random_tick();
        i2cw_pkg::req_t w;
        w            = REQ_W'($urandom);
        w.kind       = i2cw_pkg::KIND_TICK;
        return w;
    endfunction

    function automatic stim_row_t make_row(input logic k, input logic [7:0] d,
                                           input logic f, input logic l,
                                           input logic s, input bit has_fixed,
                                           input i2cw_pkg::rsp_t fixed_rsp);
        stim_row_t row;
        row.word.kind       = k;
        row.word.data_byte  = d;
        row.word.first_byte = f;
        row.word.last_byte  = l;
        row.word.sda_level  = s;
        row.has_fixed       = has_fixed;
        row.fixed_rsp       = fixed_rsp;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Response side. The stall is picked at the falling edge and the word is
    // checked at the rising edge. Once, after enough responses, the receiver
    // holds off for a long stretch so that the output buffer fills and the
    // block has to stall its request side.
    // ------------------------------------------------------------------------
    int unsigned rsp_seen      = 0;
    int unsigned err_count     = 0;
    bit          pressure_done = 1'b0;

    initial
    begin
        int stall_left;
        int pick;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (!pressure_done && rsp_seen >= PRESSURE_AT)
                begin
                    pressure_done = 1'b1;
                    stall_left    = PRESSURE_LEN;
                end
                else if ((rsp_seen / 100) % 3 == 1 || pick < 70)
                begin
                    // Every third block of a hundred responses runs unstalled.
                    stall_left = 0;
                end
                else if (pick < 95)
                begin
                    stall_left = $urandom_range(1, 3);
                end
                else
                begin
                    stall_left = $urandom_range(10, 40);
                end
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Field names by bit position of rsp_t, least significant first.
    const string rsp_field_name[6] = '{"rejected", "nack", "ack_valid",
                                       "ready_res", "sda_release", "scl_release"};

    always @(posedge clk)
    begin
        i2cw_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen <= rsp_seen + 1;
            if (line_levels_due.size() == 0)
            begin
                err_count++;
                if (err_count <= ERR_PRINT)
                begin
                    $display("%0t: response word %b arrived with nothing expected",
                             $realtime, rsp_word);
                end
            end
            else
            begin
                want = line_levels_due.pop_front();
                for (int i = 0; i < $bits(i2cw_pkg::rsp_t); i++)
                begin
                    if (rsp_word[i] !== want[i])
                    begin
                        err_count++;
                        if (err_count <= ERR_PRINT)
                        begin
                            $display("%0t: %s expected %b actual %b (word %0d)",
                                     $realtime, rsp_field_name[i], want[i],
                                     rsp_word[i], rsp_seen);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t      directed[$];
        i2cw_pkg::req_t w;
        int unsigned    work_done;
        int             n_in_txn;

        // Hold reset, then release it away from the rising edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. A tick while idle after reset, a byte of all ones
        // submitted without the first flag and with no transaction open (a
        // start is still sent), a submit while busy, then the whole byte with
        // the data and flag fields of the ticks set to show they are ignored.
        // The acknowledge is sampled high, so the byte is not acknowledged.
        // No stop follows, so an all-zero byte then goes out inside the open
        // transaction with no start, and carries the stop flag.
        directed.push_back(make_row(i2cw_pkg::KIND_TICK, 8'h5A, 1'b1, 1'b1, 1'b0,
                                    1'b1, RSP_IDLE_RELEASED));
        directed.push_back(make_row(i2cw_pkg::KIND_SUBMIT, 8'hFF, 1'b0, 1'b0, 1'b0,
                                    1'b1, RSP_BUSY_RELEASED));
        directed.push_back(make_row(i2cw_pkg::KIND_SUBMIT, 8'h00, 1'b1, 1'b1, 1'b1,
                                    1'b1, RSP_BUSY_REJECTED));
        for (int i = 0; i < 18; i++)
        begin
            // Two start ticks and sixteen bit ticks.
            directed.push_back(make_row(i2cw_pkg::KIND_TICK, 8'hA5, i[0], i[1], i[2],
                                        1'b0, '0));
        end
        directed.push_back(make_row(i2cw_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0,
                                    1'b0, '0));
        directed.push_back(make_row(i2cw_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b1,
                                    1'b1, RSP_NACK_SAMPLED));
        directed.push_back(make_row(i2cw_pkg::KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b0,
                                    1'b0, '0));
        directed.push_back(make_row(i2cw_pkg::KIND_SUBMIT, 8'h00, 1'b0, 1'b1, 1'b0,
                                    1'b0, '0));

        foreach (directed[i])
        begin
            send_word(directed[i].word, directed[i].has_fixed, directed[i].fixed_rsp);
        end

        // Random part: mostly well-formed write transactions of one to four
        // bytes with random data, flags and acknowledge levels, with submits
        // thrown in while busy and the odd idle tick between transactions.
        work_done = directed.size();
        while (work_done < WORK_WORDS)
        begin
            sender_calm = ((work_done / 64) % 4 == 3);
            // Finish whatever is in flight, including an earlier stop.
            while (seq_phase != i2cw_pkg::PH_IDLE)
            begin
                send_word(random_tick(), 1'b0, '0);
                work_done++;
            end
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : 0)
            begin
                send_word(random_tick(), 1'b0, '0);
            end
            n_in_txn = $urandom_range(1, 4);
            for (int b = 0; b < n_in_txn; b++)
            begin
                w            = REQ_W'($urandom);
                w.kind       = i2cw_pkg::KIND_SUBMIT;
                // The first byte usually asks for a start; a later byte asks
                // for a repeated start now and then. The last byte usually
                // ends with a stop, but some transactions are left open.
                w.first_byte = (b == 0) ? ($urandom_range(0, 3) != 0)
                                        : ($urandom_range(0, 7) == 0);
                w.last_byte  = (b == n_in_txn - 1) ? ($urandom_range(0, 4) != 0)
                                                   : ($urandom_range(0, 15) == 0);
                send_word(w, 1'b0, '0);
                work_done++;
                while (seq_phase != i2cw_pkg::PH_IDLE
                       && seq_phase != i2cw_pkg::PH_STOP_A)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        w      = REQ_W'($urandom);
                        w.kind = i2cw_pkg::KIND_SUBMIT;
                        send_word(w, 1'b0, '0);
                    end
                    else
                    begin
                        send_word(random_tick(), 1'b0, '0);
                        work_done++;
                    end
                end
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;

        // Wait for every expected response, then drain for DRAIN_CYCLES so that
        // a stray extra word would still be caught.
        while (line_levels_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes sent, %0d acked, %0d not acked, %0d stops, %0d restarts,",
                 n_bytes_taken, n_ack, n_nack, n_stops, n_restarts);
        $display("%0d busy submits refused, %0d idle ticks, %0d responses, %0d mismatches.",
                 n_rejected, n_idle_ticks, rsp_seen, err_count);
        if (err_count == 0)
        begin
            $display("i2c_master_byte_writer_top test passed");
        end
        else
        begin
            $display("i2c_master_byte_writer_top test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/i2cw_pkg.sv
hdl/i2cw_seq.sv
hdl/i2c_master_byte_writer_top.sv
bench/tb_i2c_master_byte_writer_top.sv
